// File: hw/rtl/avgseg_pkg.sv
`timescale 1ns / 1ps

package avgseg_pkg;

   // Field widths
   localparam int SAMPLE_W  = 10;
   localparam int READING_W = 13;
   localparam int SEG_W     = 8;
   localparam int INDEX_W   = 2;
   localparam int DIGIT_W   = 4;

   // Stream word widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = INDEX_W;

   // Scale raw sample to tenths of a degree: sample * 5000 >> 10
   localparam int SCALE_MUL_W = 13;
   localparam int SCALE_PROD_W = SAMPLE_W + SCALE_MUL_W;
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 13'd5000;
   localparam int SCALE_SHIFT = 10;

   // Reciprocal constants for exact division of a 13-bit value
   localparam int DIV10_MUL_W = 14;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 14'd13108;
   localparam int DIV10_SHIFT = 17;

   localparam int DIV100_MUL_W = 14;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 14'd10486;
   localparam int DIV100_SHIFT = 20;

   localparam int DIV1000_MUL_W = 14;
   localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 14'd8389;
   localparam int DIV1000_SHIFT = 23;

   // Quotient widths (values of a 13-bit reading divided by 10, 100, 1000)
   localparam int Q1_W = 10;
   localparam int Q2_W = 7;
   localparam int Q3_W = 4;

   // Digit position codes carried in tuser
   localparam logic [INDEX_W-1:0] DIGIT_TENTHS = 2'd0;
   localparam logic [INDEX_W-1:0] DIGIT_UNITS  = 2'd1;
   localparam logic [INDEX_W-1:0] DIGIT_TENS   = 2'd2;

   localparam logic [SEG_W-1:0] DOT_SEGMENT = 8'b0000_0100;

   typedef logic [SEG_W-1:0] seg_type;

   function automatic seg_type digit_to_seg(input logic [DIGIT_W-1:0] digit);
      seg_type seg;
      unique case (digit)
         4'd0:    seg = 8'b1110_1011;
         4'd1:    seg = 8'b1000_1000;
         4'd2:    seg = 8'b1011_0011;
         4'd3:    seg = 8'b1011_1010;
         4'd4:    seg = 8'b1101_1000;
         4'd5:    seg = 8'b0111_1010;
         4'd6:    seg = 8'b0111_1011;
         4'd7:    seg = 8'b1010_1000;
         4'd8:    seg = 8'b1111_1011;
         4'd9:    seg = 8'b1111_1010;
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

// File: hw/rtl/averaged_reading_to_seven_segment.sv
`timescale 1ns / 1ps

// Averaged reading to seven-segment digits.
//
// Input stream (req_*): one transfer carries one raw 10-bit converter sample.
// The sample is scaled to tenths of a degree, written into a ring of
// AVG_DEPTH readings, and the truncated mean of the whole ring is shown.
// Output stream (rsp_*): each sample yields two or three transfers, the
// tenths digit, then the units digit with its dot lit, then the tens digit
// only when it is nonzero; tlast marks the final digit of the run. Every
// transfer of a run carries the same averaged reading.
// The sample is registered on entry, then passes the scale multiply, ring
// sum, mean multiply and digit split registers to the output register.
// The output register drains one digit per cycle while rsp_tready is high
// and takes the next sample's digits only after a run's last digit; the
// five-stage pipe in front of it keeps taking samples while digits wait,
// so req_tready stays high until the pipe is full.
// Reset clears the ring to zero, so early averages are pulled low until the
// ring has been filled. When rsp_tready is low the presented digit holds and
// the pipe stalls behind it once every stage is occupied.

module averaged_reading_to_seven_segment #(
   parameter int AVG_DEPTH = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [9:0] sample, [15:10] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [avgseg_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: [7:0] segments, [20:8] average, [23:21] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [avgseg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: [1:0] digit_index
   output logic [avgseg_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                                rsp_tlast
);

   import avgseg_pkg::*;

   // Ring and mean sizing, all derived from the depth
   localparam int SLOT_W   = $clog2(AVG_DEPTH);
   localparam int SUM_W    = READING_W + $clog2(AVG_DEPTH);
   localparam int DIV_K    = SUM_W + $clog2(AVG_DEPTH);
   localparam int RECIP_W  = SUM_W + 1;
   localparam longint RECIP_VAL = ((64'd1 << DIV_K) + AVG_DEPTH - 1) / AVG_DEPTH;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int MEAN_PROD_W = SUM_W + RECIP_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);

   // Pipeline stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_v_ff;
   logic en1, en2, en3, en4, en5, en_out;

   // Stage payloads
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [READING_W-1:0] scaled_ff, scaled_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [READING_W-1:0] avg4_ff, avg4_in;
   logic [READING_W-1:0] avg5_ff;
   logic [Q1_W-1:0]      q1_ff, q1_in;
   logic [Q2_W-1:0]      q2_ff, q2_in;
   logic [Q3_W-1:0]      q3_ff, q3_in;

   // Ring state
   logic [READING_W-1:0] history_ff [AVG_DEPTH];
   logic [SLOT_W-1:0]    slot_ff, slot_in;

   // Output register
   seg_type              seg0_ff, seg1_ff, seg2_ff;
   seg_type              seg0_in, seg1_in, seg2_in;
   logic                 tens_ff, tens_in;
   logic [READING_W-1:0] avg_out_ff;
   logic [INDEX_W-1:0]   idx_ff;

   logic [SCALE_PROD_W-1:0] scale_prod;
   logic [MEAN_PROD_W-1:0]  mean_prod;
   logic [READING_W+DIV10_MUL_W-1:0]   div10_prod;
   logic [READING_W+DIV100_MUL_W-1:0]  div100_prod;
   logic [READING_W+DIV1000_MUL_W-1:0] div1000_prod;
   logic [READING_W-1:0] rem0;
   logic [Q1_W-1:0]      rem1;
   logic [Q2_W-1:0]      rem2;
   seg_type              seg_mux;

   // Stall chain: a stage moves when it is empty or its successor moves
   assign en_out = !out_v_ff || (rsp_tready && rsp_tlast);
   assign en5    = !v5_ff || en_out;
   assign en4    = !v4_ff || en5;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign req_tready = en1;

   // Scale: sample * 5000 >> 10
   assign scale_prod = SCALE_PROD_W'(sample_ff) * SCALE_PROD_W'(SCALE_MUL);
   assign scaled_in  = scale_prod[SCALE_SHIFT +: READING_W];

   // Ring sum with the incoming reading substituted at the write slot
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
         if (slot_ff == SLOT_W'(i)) begin
            sum_in = sum_in + SUM_W'(scaled_ff);
         end else begin
            sum_in = sum_in + SUM_W'(history_ff[i]);
         end
      end
   end

   assign slot_in = (slot_ff >= LAST_SLOT) ? '0 : slot_ff + 1'b1;

   // Mean: multiply by the rounded-up reciprocal of the depth
   assign mean_prod = MEAN_PROD_W'(sum_ff) * MEAN_PROD_W'(RECIP);
   assign avg4_in   = mean_prod[DIV_K +: READING_W];

   // Decimal split: three independent reciprocal multiplies
   assign div10_prod   = (READING_W+DIV10_MUL_W)'(avg4_ff) * DIV10_MUL;
   assign div100_prod  = (READING_W+DIV100_MUL_W)'(avg4_ff) * DIV100_MUL;
   assign div1000_prod = (READING_W+DIV1000_MUL_W)'(avg4_ff) * DIV1000_MUL;
   assign q1_in = div10_prod[DIV10_SHIFT +: Q1_W];
   assign q2_in = div100_prod[DIV100_SHIFT +: Q2_W];
   assign q3_in = div1000_prod[DIV1000_SHIFT +: Q3_W];

   // Digits by subtracting ten times the next quotient (shift and add)
   assign rem0 = avg5_ff - (READING_W'({q1_ff, 3'b000}) + READING_W'({q1_ff, 1'b0}));
   assign rem1 = q1_ff - (Q1_W'({q2_ff, 3'b000}) + Q1_W'({q2_ff, 1'b0}));
   assign rem2 = q2_ff - (Q2_W'({q3_ff, 3'b000}) + Q2_W'({q3_ff, 1'b0}));

   assign seg0_in = digit_to_seg(rem0[DIGIT_W-1:0]);
   assign seg1_in = digit_to_seg(rem1[DIGIT_W-1:0]) | DOT_SEGMENT;
   assign seg2_in = digit_to_seg(rem2[DIGIT_W-1:0]);
   assign tens_in = (rem2[DIGIT_W-1:0] != '0);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         idx_ff   <= DIGIT_TENTHS;
         slot_ff  <= '0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         // Write the ring as the reading enters the sum stage
         if (en3 && v2_ff) begin
            history_ff[slot_ff] <= scaled_ff;
            slot_ff             <= slot_in;
         end
         if (en_out) begin
            out_v_ff <= v5_ff;
            idx_ff   <= DIGIT_TENTHS;
         end else if (rsp_tready) begin
            // advance to the next digit of the run
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (en1) sample_ff <= req_tdata[SAMPLE_W-1:0];
      if (en2) scaled_ff <= scaled_in;
      if (en3) sum_ff    <= sum_in;
      if (en4) avg4_ff   <= avg4_in;
      if (en5) begin
         avg5_ff <= avg4_ff;
         q1_ff   <= q1_in;
         q2_ff   <= q2_in;
         q3_ff   <= q3_in;
      end
      if (en_out) begin
         seg0_ff    <= seg0_in;
         seg1_ff    <= seg1_in;
         seg2_ff    <= seg2_in;
         tens_ff    <= tens_in;
         avg_out_ff <= avg5_ff;
      end
   end

   // Present the digit selected by the run position
   always_comb begin
      case (idx_ff)
         DIGIT_TENTHS: seg_mux = seg0_ff;
         DIGIT_UNITS:  seg_mux = seg1_ff;
         DIGIT_TENS:   seg_mux = seg2_ff;
         default:      seg_mux = seg0_ff;
      endcase
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_TDATA_W'({avg_out_ff, seg_mux});
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == DIGIT_TENS) || ((idx_ff == DIGIT_UNITS) && !tens_ff);

endmodule

// File: hw/rtl/avgseg_checker.sv
`timescale 1ns / 1ps

module avgseg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [avgseg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [avgseg_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input logic                                rsp_tlast
);

   import avgseg_pkg::*;

   // A stalled digit holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled digit changed");

   // A run continues at once with the next digit position
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 1'b1))
      else $error("digit run broken");

   // The averaged reading is the same throughout a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tdata[20:8] == $past(rsp_tdata[20:8]))
      else $error("average changed within a run");

   // A run ends on the units or the tens digit, and the tens digit always ends it
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tlast == (rsp_tuser == DIGIT_TENS)) ||
         (rsp_tuser == DIGIT_UNITS))
      else $error("run ends at wrong digit");

   // Only the units digit lights the dot
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2] == (rsp_tuser == DIGIT_UNITS)))
      else $error("dot on wrong digit");

endmodule

bind averaged_reading_to_seven_segment avgseg_checker u_avgseg_checker (.*);
